// ===== src/mlfq_pkg.sv =====
// Shared types and constants for the three-level feedback-queue scheduler.
// Holds item and result structs, sequencer states and shared-unit requests.
// No dependencies.
package mlfq_pkg;

    localparam int LEVELS    = 3;
    localparam int BURST_W   = 12;
    localparam int TIME_W    = 16;
    localparam int SUM_W     = 19;
    localparam int QUANTUM_W = 8;
    localparam int JOB_W     = 3;
    localparam int LVL_W     = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM3 = 2'd2;

    // Reset values of the quantum registers
    localparam logic [QUANTUM_W-1:0] QUANTUM1_RST = 8'd1;
    localparam logic [QUANTUM_W-1:0] QUANTUM2_RST = 8'd2;
    localparam logic [QUANTUM_W-1:0] QUANTUM3_RST = 8'd4;

    // Level indexes
    localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID    = 2'd1;
    localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd2;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_DISPATCH = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_SLICE   = 2'd0,
        ST_LOADED  = 2'd1,
        ST_REFUSED = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [BURST_W-1:0] burst;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [LVL_W-1:0]   level;
        logic [JOB_W-1:0]   job;
        logic [TIME_W-1:0]  slice_start;
        logic [TIME_W-1:0]  slice_end;
        logic               finished;
        logic [TIME_W-1:0]  return_time;
        logic [TIME_W-1:0]  wait_time;
        logic [SUM_W-1:0]   total_wait;
        logic [SUM_W-1:0]   total_return;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_CLAMP,
        S_ADV_NOW,
        S_UPD_REM,
        S_UPD_EXEC,
        S_CALC_WAIT,
        S_SUM_WAIT,
        S_SUM_RET
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] y;
        logic             borrow;
    } alu_rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic single;
    } fifo_stat_t;

endpackage

// ===== src/mlfq_alu.sv =====
// Shared add/subtract unit of the scheduler; the sequencer reuses it in each arithmetic step.
// Subtraction also reports a borrow, used as the less-than compare.
// Depends on mlfq_pkg.
module mlfq_alu
    import mlfq_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [SUM_W:0] ext;

    // Add or subtract with one extra bit for the borrow
    always_comb
    begin
        case (req.op)
            ALU_ADD: ext = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: ext = {1'b0, req.a} - {1'b0, req.b};
            default: ext = '0;
        endcase
        rsp.y      = ext[SUM_W-1:0];
        rsp.borrow = (req.op == ALU_SUB) && ext[SUM_W];
    end

endmodule

// ===== src/mlfq_level_fifo.sv =====
// Circular queue of job slots for one priority level.
// Head slot is read combinationally; push and pop may share a cycle.
// Depends on mlfq_pkg.
module mlfq_level_fifo
    import mlfq_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int SLOT_W = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fifo_ctrl_t        ctrl,
    input  logic [SLOT_W-1:0] push_slot,
    output fifo_stat_t        stat,
    output logic [SLOT_W-1:0] head_slot
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [SLOT_W-1:0] mem_reg [DEPTH];
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    tail_wrap;
    logic [IDX_W-1:0]  tail_idx;
    logic              push_ok;

    // Locate the tail, wrapping once past the end
    always_comb
    begin
        tail_sum  = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
        tail_wrap = (tail_sum >= (CNT_W+1)'(DEPTH)) ? tail_sum - (CNT_W+1)'(DEPTH) : tail_sum;
        tail_idx  = tail_wrap[IDX_W-1:0];
        push_ok   = ctrl.push && (count_reg < CNT_W'(DEPTH));
    end

    // Advance head and count
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push_ok) - CNT_W'(ctrl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed slot
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[tail_idx] <= push_slot;
        end
    end

    assign head_slot   = mem_reg[head_reg];
    assign stat.empty  = (count_reg == '0);
    assign stat.single = (count_reg == CNT_W'(1));

endmodule

// ===== src/mlfq_ctrl.sv =====
// Sequencer and job records of the scheduler: steps one dispatch through the
// shared add/subtract unit, keeps time, sums and per-slot records.
// Depends on mlfq_pkg; drives mlfq_alu and the three mlfq_level_fifo queues.
module mlfq_ctrl
    import mlfq_pkg::*;
#(
    parameter int MAX_JOBS = 8,
    parameter int SLOT_W   = 3,
    parameter int CNT_W    = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  in_item_t                      item,
    output logic                          busy,
    output logic                          done,
    output out_item_t                     result,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [QUANTUM_W-1:0]          cfg_data,
    output alu_req_t                      alu_req,
    input  alu_rsp_t                      alu_rsp,
    output fifo_ctrl_t [LEVELS-1:0]       fifo_ctrl,
    output logic [SLOT_W-1:0]             push_slot,
    input  fifo_stat_t [LEVELS-1:0]       fifo_stat,
    input  logic [LEVELS-1:0][SLOT_W-1:0] head_slot
);

    state_t                state_reg;
    state_t                state_next;

    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     now_next;
    logic [CNT_W-1:0]      jobs_reg;
    logic [CNT_W-1:0]      jobs_next;
    logic                  started_reg;
    logic                  started_next;
    logic [SUM_W-1:0]      sum_wait_reg;
    logic [SUM_W-1:0]      sum_wait_next;
    logic [SUM_W-1:0]      sum_return_reg;
    logic [SUM_W-1:0]      sum_return_next;
    logic [QUANTUM_W-1:0]  quantum_reg [LEVELS];
    logic [QUANTUM_W-1:0]  quantum_next [LEVELS];
    logic                  done_reg;
    logic                  done_next;
    out_item_t             result_reg;
    out_item_t             result_next;

    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [LVL_W-1:0]      level_reg;
    logic [LVL_W-1:0]      level_next;
    logic [QUANTUM_W-1:0]  q_reg;
    logic [QUANTUM_W-1:0]  q_next;
    logic                  unlimited_reg;
    logic                  unlimited_next;
    logic [BURST_W-1:0]    run_reg;
    logic [BURST_W-1:0]    run_next;
    logic [TIME_W-1:0]     start_time_reg;
    logic [TIME_W-1:0]     start_time_next;
    logic [TIME_W-1:0]     wait_reg;
    logic [TIME_W-1:0]     wait_next;
    logic                  left_reg;
    logic                  left_next;

    logic [BURST_W-1:0]    remaining_reg [MAX_JOBS];
    logic [BURST_W-1:0]    executed_reg [MAX_JOBS];
    logic [SLOT_W-1:0]     rec_addr;
    logic                  rem_we;
    logic                  exec_we;
    logic [BURST_W-1:0]    rem_wdata;
    logic [BURST_W-1:0]    exec_wdata;
    logic [BURST_W-1:0]    rem_rd;
    logic [BURST_W-1:0]    exec_rd;

    logic                  accept;
    logic                  any_ready;
    logic [LVL_W-1:0]      pick_lv;
    logic [LVL_W-1:0]      down_lv;
    logic                  slots_full;

    assign accept     = start && (state_reg == S_IDLE);
    assign rem_rd     = remaining_reg[slot_reg];
    assign exec_rd    = executed_reg[slot_reg];
    assign slots_full = (jobs_reg >= CNT_W'(MAX_JOBS));
    assign any_ready  = !fifo_stat[0].empty || !fifo_stat[1].empty || !fifo_stat[2].empty;
    assign down_lv    = (level_reg == LVL_BOTTOM) ? LVL_BOTTOM : level_reg + 1'b1;

    // Pick the highest non-empty level
    always_comb
    begin
        if (!fifo_stat[0].empty)
        begin
            pick_lv = LVL_TOP;
        end
        else if (!fifo_stat[1].empty)
        begin
            pick_lv = LVL_MID;
        end
        else
        begin
            pick_lv = LVL_BOTTOM;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.op == OP_DISPATCH))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:      state_next = any_ready ? S_CLAMP : S_IDLE;
            S_CLAMP:     state_next = S_ADV_NOW;
            S_ADV_NOW:   state_next = S_UPD_REM;
            S_UPD_REM:   state_next = S_UPD_EXEC;
            S_UPD_EXEC:  state_next = S_CALC_WAIT;
            S_CALC_WAIT: state_next = left_reg ? S_IDLE : S_SUM_WAIT;
            S_SUM_WAIT:  state_next = S_SUM_RET;
            S_SUM_RET:   state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs per step
    always_comb
    begin
        now_next        = now_reg;
        jobs_next       = jobs_reg;
        started_next    = started_reg;
        sum_wait_next   = sum_wait_reg;
        sum_return_next = sum_return_reg;
        quantum_next    = quantum_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        slot_next       = slot_reg;
        level_next      = level_reg;
        q_next          = q_reg;
        unlimited_next  = unlimited_reg;
        run_next        = run_reg;
        start_time_next = start_time_reg;
        wait_next       = wait_reg;
        left_next       = left_reg;
        alu_req.op      = ALU_ADD;
        alu_req.a       = '0;
        alu_req.b       = '0;
        fifo_ctrl       = '0;
        push_slot       = slot_reg;
        rec_addr        = slot_reg;
        rem_we          = 1'b0;
        exec_we         = 1'b0;
        rem_wdata       = rem_rd;
        exec_wdata      = exec_rd;

        // Take configuration writes; unknown indexes are dropped
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUANTUM1: quantum_next[0] = cfg_data;
                CFG_QUANTUM2: quantum_next[1] = cfg_data;
                CFG_QUANTUM3: quantum_next[2] = cfg_data;
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_LOAD)
                    begin
                        result_next              = '0;
                        result_next.total_wait   = sum_wait_reg;
                        result_next.total_return = sum_return_reg;
                        done_next                = 1'b1;
                        if (started_reg || slots_full)
                        begin
                            result_next.status = ST_REFUSED;
                        end
                        else
                        begin
                            // Store the job and append it to the top level
                            rec_addr             = jobs_reg[SLOT_W-1:0];
                            rem_we               = 1'b1;
                            exec_we              = 1'b1;
                            rem_wdata            = item.burst;
                            exec_wdata           = '0;
                            push_slot            = jobs_reg[SLOT_W-1:0];
                            fifo_ctrl[0].push    = 1'b1;
                            jobs_next            = jobs_reg + 1'b1;
                            result_next.status   = ST_LOADED;
                            result_next.job      = JOB_W'(jobs_reg[SLOT_W-1:0]);
                        end
                    end
                    else
                    begin
                        started_next = 1'b1;
                    end
                end
            end
            S_PICK:
            begin
                if (!any_ready)
                begin
                    result_next              = '0;
                    result_next.status       = ST_NONE;
                    result_next.slice_start  = now_reg;
                    result_next.slice_end    = now_reg;
                    result_next.total_wait   = sum_wait_reg;
                    result_next.total_return = sum_return_reg;
                    done_next                = 1'b1;
                end
                else
                begin
                    // Pop the head and fix the slice limit
                    fifo_ctrl[pick_lv].pop = 1'b1;
                    slot_next       = head_slot[pick_lv];
                    level_next      = pick_lv;
                    q_next          = quantum_reg[pick_lv];
                    unlimited_next  = (quantum_reg[pick_lv] == '0) ||
                                      ((pick_lv == LVL_BOTTOM) && fifo_stat[2].single);
                    start_time_next = now_reg;
                end
            end
            S_CLAMP:
            begin
                // Compare quantum against remaining time
                alu_req.op = ALU_SUB;
                alu_req.a  = SUM_W'(q_reg);
                alu_req.b  = SUM_W'(rem_rd);
                run_next   = (!unlimited_reg && alu_rsp.borrow) ? BURST_W'(q_reg) : rem_rd;
            end
            S_ADV_NOW:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = SUM_W'(now_reg);
                alu_req.b  = SUM_W'(run_reg);
                now_next   = alu_rsp.y[TIME_W-1:0];
            end
            S_UPD_REM:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = SUM_W'(rem_rd);
                alu_req.b  = SUM_W'(run_reg);
                rem_we     = 1'b1;
                rem_wdata  = alu_rsp.y[BURST_W-1:0];
                left_next  = (alu_rsp.y[BURST_W-1:0] != '0);
            end
            S_UPD_EXEC:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = SUM_W'(exec_rd);
                alu_req.b  = SUM_W'(run_reg);
                exec_we    = 1'b1;
                exec_wdata = alu_rsp.y[BURST_W-1:0];
            end
            S_CALC_WAIT:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = SUM_W'(now_reg);
                alu_req.b  = SUM_W'(exec_rd);
                wait_next  = alu_rsp.y[TIME_W-1:0];
                if (left_reg)
                begin
                    // Push the unfinished job one level down (the bottom level keeps it) and report the slice
                    fifo_ctrl[down_lv].push  = 1'b1;
                    result_next              = '0;
                    result_next.status       = ST_SLICE;
                    result_next.level        = level_reg;
                    result_next.job          = JOB_W'(slot_reg);
                    result_next.slice_start  = start_time_reg;
                    result_next.slice_end    = now_reg;
                    result_next.total_wait   = sum_wait_reg;
                    result_next.total_return = sum_return_reg;
                    done_next                = 1'b1;
                end
            end
            S_SUM_WAIT:
            begin
                alu_req.op    = ALU_ADD;
                alu_req.a     = sum_wait_reg;
                alu_req.b     = SUM_W'(wait_reg);
                sum_wait_next = alu_rsp.y;
            end
            S_SUM_RET:
            begin
                alu_req.op               = ALU_ADD;
                alu_req.a                = sum_return_reg;
                alu_req.b                = SUM_W'(now_reg);
                sum_return_next          = alu_rsp.y;
                result_next              = '0;
                result_next.status       = ST_SLICE;
                result_next.level        = level_reg;
                result_next.job          = JOB_W'(slot_reg);
                result_next.slice_start  = start_time_reg;
                result_next.slice_end    = now_reg;
                result_next.finished     = 1'b1;
                result_next.return_time  = now_reg;
                result_next.wait_time    = wait_reg;
                result_next.total_wait   = sum_wait_reg;
                result_next.total_return = alu_rsp.y;
                done_next                = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            now_reg         <= '0;
            jobs_reg        <= '0;
            started_reg     <= 1'b0;
            sum_wait_reg    <= '0;
            sum_return_reg  <= '0;
            quantum_reg[0]  <= QUANTUM1_RST;
            quantum_reg[1]  <= QUANTUM2_RST;
            quantum_reg[2]  <= QUANTUM3_RST;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            now_reg         <= now_next;
            jobs_reg        <= jobs_next;
            started_reg     <= started_next;
            sum_wait_reg    <= sum_wait_next;
            sum_return_reg  <= sum_return_next;
            quantum_reg     <= quantum_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        slot_reg       <= slot_next;
        level_reg      <= level_next;
        q_reg          <= q_next;
        unlimited_reg  <= unlimited_next;
        run_reg        <= run_next;
        start_time_reg <= start_time_next;
        wait_reg       <= wait_next;
        left_reg       <= left_next;
    end

    // Job records
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            remaining_reg[rec_addr] <= rem_wdata;
        end
        if (exec_we)
        begin
            executed_reg[rec_addr] <= exec_wdata;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/mlfq_three_level_scheduler_top.sv =====
// Three-level feedback-queue scheduler, top level.
// A load is answered from the idle state; a dispatch steps through pick, clamp,
// time advance, remaining and executed updates and wait calculation, then wait
// and return sums for a finishing job, using the shared add/subtract unit.
// A new item may be taken in the strobe cycle. Reset (rst_n, async) empties all
// levels, clears time and totals, and restores quanta 1, 2 and 4.
module mlfq_three_level_scheduler_top
    import mlfq_pkg::*;
#(
    parameter int MAX_JOBS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  in_item_t             item,
    output logic                 busy,
    output logic                 done,
    output out_item_t            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [QUANTUM_W-1:0] cfg_data
);

    localparam int SLOT_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);

    alu_req_t                      alu_req;
    alu_rsp_t                      alu_rsp;
    fifo_ctrl_t [LEVELS-1:0]       fifo_ctrl;
    fifo_stat_t [LEVELS-1:0]       fifo_stat;
    logic [LEVELS-1:0][SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0]             push_slot;

    // Sequencer and records
    mlfq_ctrl #(
        .MAX_JOBS (MAX_JOBS),
        .SLOT_W   (SLOT_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .fifo_ctrl (fifo_ctrl),
        .push_slot (push_slot),
        .fifo_stat (fifo_stat),
        .head_slot (head_slot)
    );

    // Shared arithmetic unit
    mlfq_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // One queue per level
    for (genvar lv = 0; lv < LEVELS; lv++)
    begin : g_level
        mlfq_level_fifo #(
            .DEPTH  (MAX_JOBS),
            .SLOT_W (SLOT_W)
        ) u_fifo (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (fifo_ctrl[lv]),
            .push_slot (push_slot),
            .stat      (fifo_stat[lv]),
            .head_slot (head_slot[lv])
        );
    end

endmodule

// ===== src/mlfq_checker.sv =====
// Port-level checks for the scheduler top level, attached by bind.
// Depends on mlfq_pkg and mlfq_three_level_scheduler_top.
module mlfq_checker
    import mlfq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input in_item_t             item,
    input logic                 busy,
    input logic                 done,
    input out_item_t            result
);

    // A load transfer answers in the next cycle
    a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_LOAD)) |=>
            (done && ((result.status == ST_LOADED) || (result.status == ST_REFUSED))))
        else $error("load transfer not answered in the next cycle");

    // A dispatch transfer makes the block busy
    a_dispatch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == OP_DISPATCH)) |=> busy)
        else $error("dispatch transfer did not start the sequencer");

    // A finishing slice returns at its end time
    a_return_time: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.finished) |-> (result.return_time == result.slice_end))
        else $error("return time differs from slice end");

    // Only a slice can finish a job
    a_finish_slice: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_SLICE)) |-> !result.finished)
        else $error("finished flag on a result that is not a slice");

endmodule

bind mlfq_three_level_scheduler_top mlfq_checker u_mlfq_checker (.*);
